// ===== sv/utf16_to_utf8_transcoder_macros.svh =====
// Assertion helpers used by the checker module.
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

// Same-cycle implication, sampled on clk and masked while rst is high.
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and masked while rst is high.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/u16u8_pkg.sv =====
`timescale 1ns / 1ps

package u16u8_pkg;

  // Default depth of the command queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Top six bits of a surrogate code unit.
  localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
  localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_UNPAIRED_LOW = 2'd1,
    ERR_BAD_PAIR     = 2'd2,
    ERR_TRUNCATED    = 2'd3
  } err_code_t;

  // One classified unit: the bytes to send, index of the final byte,
  // end-of-string flag and error code.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            fin;
    err_code_t       err;
  } ucmd_t;

endpackage

// ===== sv/u16u8_front.sv =====
`timescale 1ns / 1ps

module u16u8_front
  import u16u8_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] code_unit,
  input  logic        final_unit,
  input  logic        q_full,
  output logic        push,
  output ucmd_t       cmd
);

  logic       high_pending;
  logic       high_pending_next;
  logic [9:0] high_bits;
  logic [9:0] high_bits_next;
  logic       accept;
  logic       is_high;
  logic       is_low;
  logic [4:0] plane;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_high  = (code_unit[15:10] == SURR_HIGH_TAG);
  assign is_low   = (code_unit[15:10] == SURR_LOW_TAG);
  assign plane    = {1'b0, high_bits[9:6]} + 5'd1;

  // Classify the unit and build its byte command
  always_comb begin
    cmd               = '0;
    cmd.fin           = final_unit;
    cmd.err           = ERR_NONE;
    push              = 1'b0;
    high_pending_next = high_pending;
    high_bits_next    = high_bits;
    if (accept) begin
      push = 1'b1;
      if (high_pending) begin
        high_pending_next = 1'b0;
        high_bits_next    = '0;
        if (!is_low) begin
          cmd.err = ERR_BAD_PAIR;
        end else begin
          cmd.bytes[0] = {5'b11110, plane[4:2]};
          cmd.bytes[1] = {2'b10, plane[1:0], high_bits[5:2]};
          cmd.bytes[2] = {2'b10, high_bits[1:0], code_unit[9:6]};
          cmd.bytes[3] = {2'b10, code_unit[5:0]};
          cmd.last_idx = 2'd3;
        end
      end else if (is_high) begin
        if (final_unit) begin
          cmd.err = ERR_TRUNCATED;
        end else begin
          // Hold the high half; nothing goes out yet
          push              = 1'b0;
          high_pending_next = 1'b1;
          high_bits_next    = code_unit[9:0];
        end
      end else if (is_low) begin
        cmd.err = ERR_UNPAIRED_LOW;
      end else if (code_unit[15:7] == '0) begin
        cmd.bytes[0] = {1'b0, code_unit[6:0]};
        cmd.last_idx = 2'd0;
      end else if (code_unit[15:11] == '0) begin
        cmd.bytes[0] = {3'b110, code_unit[10:6]};
        cmd.bytes[1] = {2'b10, code_unit[5:0]};
        cmd.last_idx = 2'd1;
      end else begin
        cmd.bytes[0] = {4'b1110, code_unit[15:12]};
        cmd.bytes[1] = {2'b10, code_unit[11:6]};
        cmd.bytes[2] = {2'b10, code_unit[5:0]};
        cmd.last_idx = 2'd2;
      end
    end
  end

  // Hold the pending surrogate
  always_ff @(posedge clk) begin
    if (rst) begin
      high_pending <= 1'b0;
      high_bits    <= '0;
    end else begin
      high_pending <= high_pending_next;
      high_bits    <= high_bits_next;
    end
  end

endmodule

// ===== sv/u16u8_queue.sv =====
`timescale 1ns / 1ps

module u16u8_queue
  import u16u8_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  ucmd_t push_cmd,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output ucmd_t head_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ucmd_t         entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/u16u8_back.sv =====
`timescale 1ns / 1ps

module u16u8_back
  import u16u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  ucmd_t      head_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] utf8_byte,
  output logic       run_last,
  output logic       string_done,
  output err_code_t  error_code
);

  ucmd_t      cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       take;

  assign out_valid   = cur_valid;
  assign utf8_byte   = cur.bytes[idx];
  assign run_last    = (idx == cur.last_idx);
  assign string_done = run_last && cur.fin;
  assign error_code  = cur.err;
  assign take        = cur_valid && out_ready;
  assign pop         = head_valid && (!cur_valid || (take && run_last));

  // Load the next command once the current one has gone out
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_cmd;
    end
  end

  // Step through the bytes of the current command
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (take) begin
      if (run_last) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

// ===== sv/utf16_to_utf8_transcoder.sv =====
`timescale 1ns / 1ps
// Channel   Role    tdata                tuser                         tlast
// s_axis    in      [15:0] code_unit     -                             final_unit
// m_axis    out     [7:0]  utf8_byte     [0] run_last, [2:1] error     string_done
//
// A unit gives one output word per UTF-8 byte, 1 to 4 words, or one word for an
// error result; a held high surrogate is taken in and sends nothing.
// The back end's byte stepper, one byte a cycle on m_axis while m_axis_tready is high, sets the rate.
// Input takes a new unit each cycle while the QUEUE_DEPTH-entry queue has room.
// rst is synchronous and clears the held surrogate, the queue and the output.

module utf16_to_utf8_transcoder
  import u16u8_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] utf8_byte
  output logic [2:0]  m_axis_tuser,   // [0] run_last, [2:1] error_code
  output logic        m_axis_tlast
);

  ucmd_t     push_cmd;
  ucmd_t     head_cmd;
  logic      push;
  logic      q_full;
  logic      head_valid;
  logic      pop;
  logic      run_last;
  err_code_t error_code;

  u16u8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .code_unit  (s_axis_tdata),
    .final_unit (s_axis_tlast),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  u16u8_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .utf8_byte   (m_axis_tdata),
    .run_last    (run_last),
    .string_done (m_axis_tlast),
    .error_code  (error_code)
  );

  assign m_axis_tuser = {error_code, run_last};

endmodule

// ===== sv/u16u8_checker.sv =====
`timescale 1ns / 1ps
`include "utf16_to_utf8_transcoder_macros.svh"

module u16u8_checker
  import u16u8_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // A stalled word keeps its byte
  `CHK_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled byte changed")

  // Error results carry a zero byte and close their run
  `CHK_IMPLY(a_err, m_axis_tvalid && (m_axis_tuser[2:1] != ERR_NONE), (m_axis_tdata == 8'd0) && m_axis_tuser[0], "bad error result")

  // End of string only on the last word of a run
  `CHK_IMPLY(a_done, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0], "string end inside a run")

  // A word after a non-final byte of a run is a continuation byte
  `CHK_IMPLY(a_cont, $past(m_axis_tvalid && m_axis_tready && !m_axis_tuser[0]) && m_axis_tvalid, m_axis_tdata[7:6] == 2'b10, "missing continuation byte")

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/utf16_to_utf8_transcoder_tb.sv =====
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_tb;
  import u16u8_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int QUIET_TAIL  = 40;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [15:0] unit;
    logic        fin;
    logic        hold;   // wait for every expected word before sending
  } unit_item_t;

  typedef struct packed {
    logic [7:0] utf8_val;
    logic       run_last;
    logic       string_done;
    err_code_t  err;
  } utf8_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] code_unit
  logic        s_axis_tlast = 1'b0; // final_unit
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] utf8_byte
  logic [2:0]  m_axis_tuser;        // [0] run_last, [2:1] error_code
  logic        m_axis_tlast;        // string_done

  unit_item_t pending_units[$];
  utf8_word_t expected_bytes[$];

  // Shadow of the held high surrogate
  logic       held_valid = 1'b0;
  logic [9:0] held_bits = '0;

  int fail_count = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int stall_left = 0;

  utf16_to_utf8_transcoder u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  task automatic add_unit(input logic [15:0] unit, input logic fin, input logic hold = 1'b0);
    unit_item_t item;
    item.unit = unit;
    item.fin  = fin;
    item.hold = hold;
    pending_units = {pending_units, item};
  endtask

  // Single error word; clears any held surrogate
  task automatic push_error(input logic fin, input err_code_t code);
    utf8_word_t w;
    w.utf8_val    = 8'h00;
    w.run_last    = 1'b1;
    w.string_done = fin;
    w.err         = code;
    expected_bytes = {expected_bytes, w};
    held_valid = 1'b0;
    held_bits  = '0;
  endtask

  // Work out the UTF-8 words that one accepted code unit produces
  task automatic encode_unit(input logic [15:0] unit, input logic fin);
    logic        is_high;
    logic        is_low;
    logic        emit;
    logic [20:0] cp;
    logic [7:0]  b [4];
    int          n;
    utf8_word_t  w;
    is_high = (unit >= 16'hD800) && (unit <= 16'hDBFF);
    is_low  = (unit >= 16'hDC00) && (unit <= 16'hDFFF);
    emit = 1'b0;
    cp = '0;
    if (held_valid) begin
      if (!is_low) begin
        push_error(fin, ERR_BAD_PAIR);
      end else begin
        cp = 21'h10000 + {1'b0, held_bits, unit[9:0]};
        held_valid = 1'b0;
        held_bits  = '0;
        emit = 1'b1;
      end
    end else if (is_high) begin
      if (fin) begin
        push_error(fin, ERR_TRUNCATED);
      end else begin
        held_valid = 1'b1;
        held_bits  = unit[9:0];
      end
    end else if (is_low) begin
      push_error(fin, ERR_UNPAIRED_LOW);
    end else begin
      cp = {5'd0, unit};
      emit = 1'b1;
    end
    if (emit) begin
      if (cp <= 21'h7F) begin
        b[0] = cp[7:0];
        n = 1;
      end else if (cp <= 21'h7FF) begin
        b[0] = {3'b110, cp[10:6]};
        b[1] = {2'b10, cp[5:0]};
        n = 2;
      end else if (cp <= 21'hFFFF) begin
        b[0] = {4'b1110, cp[15:12]};
        b[1] = {2'b10, cp[11:6]};
        b[2] = {2'b10, cp[5:0]};
        n = 3;
      end else begin
        b[0] = {5'b11110, cp[20:18]};
        b[1] = {2'b10, cp[17:12]};
        b[2] = {2'b10, cp[11:6]};
        b[3] = {2'b10, cp[5:0]};
        n = 4;
      end
      for (int k = 0; k < n; k++) begin
        w.utf8_val    = b[k];
        w.run_last    = (k == n - 1);
        w.string_done = (k == n - 1) && fin;
        w.err         = ERR_NONE;
        expected_bytes = {expected_bytes, w};
      end
    end
  endtask

  // Driver: present pending code units, with random gaps
  always @(posedge clk) begin : drive
    logic       holding;
    unit_item_t item;
    holding = s_axis_tvalid && !s_axis_tready;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        encode_unit(s_axis_tdata, s_axis_tlast);
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_units.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (pending_units[0].hold && expected_bytes.size() != 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (pending_units.size() > QUIET_TAIL && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 8) - 1;
          s_axis_tvalid <= 1'b0;
        end else begin
          item = pending_units.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= item.unit;
          s_axis_tlast  <= item.fin;
        end
      end
    end
  end

  // Monitor: stall the output at random and check each word
  always @(posedge clk) begin : watch
    utf8_word_t want;
    utf8_word_t got;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.utf8_val    = m_axis_tdata;
        got.run_last    = m_axis_tuser[0];
        got.string_done = m_axis_tlast;
        got.err         = err_code_t'(m_axis_tuser[2:1]);
        if (expected_bytes.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected word: byte %h run_last %b done %b err %0d",
                     got.utf8_val, got.run_last, got.string_done, got.err);
        end else begin
          want = expected_bytes.pop_front();
          if (got.utf8_val !== want.utf8_val || got.run_last !== want.run_last ||
              got.string_done !== want.string_done || got.err !== want.err) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected byte %h run_last %b done %b err %0d, got byte %h run_last %b done %b err %0d",
                       want.utf8_val, want.run_last, want.string_done, want.err,
                       got.utf8_val, got.run_last, got.string_done, got.err);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (pending_units.size() > QUIET_TAIL && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: give up when no word moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles++;
      end
    end
  end

  initial begin : stimulus
    int          n;
    int          kind;
    int          count;
    logic        last;
    logic [15:0] r;
    logic        first_random;

    // Byte-length boundaries
    add_unit(16'h0000, 1'b0);
    add_unit(16'h007F, 1'b0);
    add_unit(16'h0080, 1'b0);
    add_unit(16'h07FF, 1'b0);
    add_unit(16'h0800, 1'b0);
    add_unit(16'hFFFF, 1'b1);
    // Lowest and highest supplementary code points
    add_unit(16'hD800, 1'b0);
    add_unit(16'hDC00, 1'b0);
    add_unit(16'hDBFF, 1'b0);
    add_unit(16'hDFFF, 1'b1);
    // Unpaired low surrogate, mid-string and as final unit
    add_unit(16'hDC00, 1'b0);
    add_unit(16'hDFFF, 1'b1);
    // High surrogate followed by a plain unit, then by another high
    add_unit(16'hD800, 1'b0);
    add_unit(16'h0041, 1'b0);
    add_unit(16'hDBFF, 1'b0);
    add_unit(16'hD800, 1'b0);
    // High surrogate as the final unit
    add_unit(16'hDBFF, 1'b1);
    // Ordinary pair, then units around the surrogate block
    add_unit(16'hD83D, 1'b0);
    add_unit(16'hDE00, 1'b1);
    add_unit(16'hE000, 1'b0);
    add_unit(16'hD7FF, 1'b1);
    // Bad second unit that ends the string, then recovery
    add_unit(16'hD800, 1'b0);
    add_unit(16'h0000, 1'b1);
    add_unit(16'h0041, 1'b1);

    // Random strings, mostly well formed
    count = 0;
    first_random = 1'b1;
    while (count < 136) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        last = (i == n - 1);
        kind = $urandom_range(0, 15);
        if (kind <= 3) begin
          add_unit(16'($urandom_range(0, 16'h7F)), last, first_random);
        end else if (kind <= 6) begin
          add_unit(16'($urandom_range(16'h80, 16'h7FF)), last, first_random);
        end else if (kind <= 9) begin
          r = 16'($urandom_range(16'h800, 16'hF7FF));
          if (r >= 16'hD800)
            r = r + 16'h0800;
          add_unit(r, last, first_random);
        end else if (kind <= 12) begin
          add_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0, first_random);
          add_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), last);
          count++;
        end else if (kind == 13) begin
          add_unit(16'($urandom), last, first_random);
        end else if (kind == 14) begin
          add_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), last, first_random);
        end else if (last && $urandom_range(0, 1) == 0) begin
          add_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b1, first_random);
        end else begin
          add_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0, first_random);
          r = 16'($urandom);
          if (r >= 16'hDC00 && r <= 16'hDFFF)
            r = r - 16'h0400;
          add_unit(r, last);
          count++;
        end
        first_random = 1'b0;
        count++;
      end
      // Occasionally drain the output before the last unit of the string
      if ($urandom_range(0, 9) == 0)
        pending_units[pending_units.size() - 1].hold = 1'b1;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait for every unit to go in and every word to come out
    while (pending_units.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_bytes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
